// ===== rtl/core/serial_frame_receiver_crc8_macros.svh =====
// Assertion macros shared by the frame receiver RTL.
// Every assertion is clocked on clk_i; the first form is also gated by rst_ni.
`ifndef SERIAL_FRAME_RECEIVER_CRC8_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CRC8_MACROS_SVH

// Checked only while out of reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, including during reset.
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/sfr_pkg.sv =====
// Shared types, constants and the CRC-8 step for the frame receiver.
// No dependencies.
`default_nettype none

package sfr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [ByteW-1:0] Crc8Poly = 8'h07;

  // register reset values
  localparam logic [ByteW-1:0] StartByteRst = 8'd126;
  localparam logic [ByteW-1:0] MaxLenRst    = 8'd251;
  localparam logic             CrcEnRst     = 1'b1;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgStartByte = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgMaxLen    = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgCrcEn     = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] StData   = 2'd0;
  localparam logic [StatusW-1:0] StGood   = 2'd1;
  localparam logic [StatusW-1:0] StCrcErr = 2'd2;
  localparam logic [StatusW-1:0] StLenErr = 2'd3;

  // command queue
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_ID      = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CRC     = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,  // payload begins: clear running CRC, no result
    OP_DATA   = 2'd1,  // payload byte
    OP_CHECK  = 2'd2,  // trailing CRC byte
    OP_LENERR = 2'd3   // length over limit
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] idx;
  } cmd_t;

  // CRC-8, MSB first, init 0, no reflection, no final xor
  function automatic logic [ByteW-1:0] crc8_step(logic [ByteW-1:0] crc,
                                                 logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      c = c[ByteW-1] ? ((c << 1) ^ Crc8Poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/serial_frame_receiver_crc8.sv =====
// Top level of the length-prefixed frame receiver with CRC-8 check.
// Depends on sfr_pkg, sfr_front, sfr_fifo, sfr_back.
//
// Takes one received byte per cycle while in_stall_o is low; sustained rate is
// one byte per clock when the output is not stalled, limited by the parser and
// the bytewise CRC in the executor. A byte that produces a result enters the
// command queue at the accepting edge and moves from there into the output
// register once that register is free. A two-entry queue sits between parser and
// executor, so output stall reaches the input only once the queue fills. The user
// must write configuration only while idle; the block itself does not enforce it.
`default_nettype none

module serial_frame_receiver_crc8 (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [sfr_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire  [sfr_pkg::ByteW-1:0]      cfg_wdata_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [sfr_pkg::ByteW-1:0]      rx_byte_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [sfr_pkg::StatusW-1:0]    status_o,
  output logic [sfr_pkg::ByteW-1:0]      frame_id_o,
  output logic [sfr_pkg::ByteW-1:0]      data_byte_o,
  output logic [sfr_pkg::ByteW-1:0]      byte_index_o,
  output logic                           last_o
);

  logic [sfr_pkg::ByteW-1:0] start_byte_q, max_len_q;
  logic                      crc_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= sfr_pkg::StartByteRst;
      max_len_q    <= sfr_pkg::MaxLenRst;
      crc_en_q     <= sfr_pkg::CrcEnRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfr_pkg::CfgStartByte: start_byte_q <= cfg_wdata_i;
        sfr_pkg::CfgMaxLen:    max_len_q    <= cfg_wdata_i;
        sfr_pkg::CfgCrcEn:     crc_en_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic          accept, push, pop, empty, full;
  sfr_pkg::cmd_t push_cmd, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .start_byte_i (start_byte_q),
    .max_len_i    (max_len_q),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  sfr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  sfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .crc_en_i     (crc_en_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .frame_id_o   (frame_id_o),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sfr_front.sv =====
// Front end: frame parser that classifies each received byte into a command.
// Depends on sfr_pkg.
`default_nettype none

module sfr_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       accept_i,
  input  wire  [sfr_pkg::ByteW-1:0] rx_byte_i,
  input  wire  [sfr_pkg::ByteW-1:0] start_byte_i,
  input  wire  [sfr_pkg::ByteW-1:0] max_len_i,
  output logic                      push_o,
  output sfr_pkg::cmd_t             cmd_o
);

  sfr_pkg::phase_e             phase_q, phase_d;
  logic [sfr_pkg::ByteW-1:0]   id_q, id_d;
  logic [sfr_pkg::ByteW-1:0]   len_q, len_d;
  logic [sfr_pkg::ByteW-1:0]   cnt_q, cnt_d;
  logic [sfr_pkg::ByteW-1:0]   cnt_inc;

  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    phase_d    = phase_q;
    id_d       = id_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    push_o     = 1'b0;
    cmd_o.op   = sfr_pkg::OP_START;
    cmd_o.id   = id_q;
    cmd_o.data = rx_byte_i;
    cmd_o.idx  = cnt_q;
    if (accept_i) begin
      unique case (phase_q)
        sfr_pkg::PH_ID: begin
          id_d    = rx_byte_i;
          phase_d = sfr_pkg::PH_LEN;
        end
        sfr_pkg::PH_LEN: begin
          push_o = 1'b1;
          if (rx_byte_i > max_len_i) begin
            cmd_o.op = sfr_pkg::OP_LENERR;
            phase_d  = sfr_pkg::PH_HUNT;
          end else begin
            cmd_o.op = sfr_pkg::OP_START;
            len_d    = rx_byte_i;
            cnt_d    = '0;
            phase_d  = (rx_byte_i == '0) ? sfr_pkg::PH_CRC : sfr_pkg::PH_PAYLOAD;
          end
        end
        sfr_pkg::PH_PAYLOAD: begin
          push_o   = 1'b1;
          cmd_o.op = sfr_pkg::OP_DATA;
          cnt_d    = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = sfr_pkg::PH_CRC;
          end
        end
        sfr_pkg::PH_CRC: begin
          push_o   = 1'b1;
          cmd_o.op = sfr_pkg::OP_CHECK;
          phase_d  = sfr_pkg::PH_HUNT;
        end
        default: begin
          phase_d = (rx_byte_i == start_byte_i) ? sfr_pkg::PH_ID : sfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfr_pkg::PH_HUNT;
      id_q    <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfr_fifo.sv =====
// Short command queue between parser and executor.
// Depends on sfr_pkg.
`default_nettype none

module sfr_fifo (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  input  sfr_pkg::cmd_t               push_data_i,
  input  wire                         pop_i,
  output sfr_pkg::cmd_t               head_o,
  output logic                        empty_o,
  output logic                        full_o
);

  sfr_pkg::cmd_t                    mem_q [sfr_pkg::FifoDepth];
  logic [sfr_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [sfr_pkg::FifoCntW-1:0]     cnt_q;

  localparam logic [sfr_pkg::FifoPtrW-1:0] LastPtr =
    sfr_pkg::FifoPtrW'(sfr_pkg::FifoDepth - 1);
  localparam logic [sfr_pkg::FifoCntW-1:0] FullCnt =
    sfr_pkg::FifoCntW'(sfr_pkg::FifoDepth);

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sfr_back.sv =====
// Back end: runs the payload CRC and builds result transfers in an output register.
// Depends on sfr_pkg and serial_frame_receiver_crc8_macros.svh.
`default_nettype none
`include "serial_frame_receiver_crc8_macros.svh"

module sfr_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  sfr_pkg::cmd_t                head_i,
  input  wire                          empty_i,
  output logic                         pop_o,
  input  wire                          crc_en_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [sfr_pkg::StatusW-1:0]  status_o,
  output logic [sfr_pkg::ByteW-1:0]    frame_id_o,
  output logic [sfr_pkg::ByteW-1:0]    data_byte_o,
  output logic [sfr_pkg::ByteW-1:0]    byte_index_o,
  output logic                         last_o
);

  logic                          out_valid_q, out_valid_d;
  logic [sfr_pkg::ByteW-1:0]     crc_q, crc_d;
  logic [sfr_pkg::StatusW-1:0]   status_q, status_d;
  logic [sfr_pkg::ByteW-1:0]     id_q, data_q, data_d, idx_q, idx_d;
  logic                          last_q, last_d;
  logic                          emit;

  // output register frees up when empty or its transfer completes
  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);
  assign emit  = pop_o && (head_i.op != sfr_pkg::OP_START);
  assign out_valid_d = (out_valid_q && out_stall_i) || emit;

  always_comb begin
    crc_d    = crc_q;
    status_d = sfr_pkg::StData;
    data_d   = '0;
    idx_d    = '0;
    last_d   = 1'b1;
    unique case (head_i.op)
      sfr_pkg::OP_START: begin
        crc_d = '0;
      end
      sfr_pkg::OP_DATA: begin
        crc_d  = sfr_pkg::crc8_step(crc_q, head_i.data);
        data_d = head_i.data;
        idx_d  = head_i.idx;
        last_d = 1'b0;
      end
      sfr_pkg::OP_CHECK: begin
        status_d = (!crc_en_i || (head_i.data == crc_q)) ? sfr_pkg::StGood
                                                         : sfr_pkg::StCrcErr;
      end
      default: begin
        status_d = sfr_pkg::StLenErr;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        crc_q <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= status_d;
      id_q     <= head_i.id;
      data_q   <= data_d;
      idx_q    <= idx_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign frame_id_o   = id_q;
  assign data_byte_o  = data_q;
  assign byte_index_o = idx_q;
  assign last_o       = last_q;

  `SFR_ASSERT(a_last_matches_status, out_valid_q |-> (last_q == (status_q != sfr_pkg::StData)), "last flag disagrees with status")
  `SFR_ASSERT(a_data_zero_on_end, (out_valid_q && last_q) |-> (data_q == '0 && idx_q == '0), "end transfer carries payload")
  `SFR_ASSERT(a_crc_cleared, (pop_o && head_i.op == sfr_pkg::OP_START) |=> (crc_q == '0), "CRC not cleared at payload start")
  `SFR_ASSERT_ALWAYS(a_no_pop_empty, pop_o |-> !empty_i, "pop from empty queue")

endmodule

`default_nettype wire
